// ===== rtl/fair_reader_writer_lock_arbiter_core_assert.svh =====
// Assertion helpers for the checker file frwl_checker.sv.
`ifndef FAIR_READER_WRITER_LOCK_ARBITER_CORE_ASSERT_SVH
`define FAIR_READER_WRITER_LOCK_ARBITER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FRWL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frwl assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FRWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frwl assertion failed");

`endif

// ===== rtl/frwl_pkg.sv =====
package frwl_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int AGENT_COUNT     = 16;
  localparam int MAX_GRANTS      = 16;
  localparam int GRANT_W         = $clog2(MAX_GRANTS + 1);
  localparam int READER_W        = 5;
  localparam logic [READER_W-1:0] READER_MAX = 5'd31;

  localparam logic OP_LOCK     = 1'b0;
  localparam logic OP_RELEASE  = 1'b1;
  localparam logic MODE_SHARED = 1'b0;
  localparam logic MODE_EXCL   = 1'b1;

  typedef enum logic [2:0] {
    ST_GRANTED      = 3'd0,
    ST_QUEUED       = 3'd1,
    ST_REJECTED     = 3'd2,
    ST_RELEASED     = 3'd3,
    ST_FREE_RELEASE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    LK_FREE   = 2'd0,
    LK_SHARED = 2'd1,
    LK_EXCL   = 2'd2
  } lock_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_READ  = 2'd1,
    S_EVAL  = 2'd2,
    S_FLUSH = 2'd3
  } state_t;

  typedef struct packed {
    logic       operation;
    logic [3:0] requester;
    logic       lock_mode;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] agent;
    logic       granted_mode;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [3:0] agent;
    logic       mode;
  } queue_entry_t;

endpackage

// ===== rtl/frwl_queue.sv =====
module frwl_queue #(
  parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  frwl_pkg::queue_entry_t         wr_data,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output frwl_pkg::queue_entry_t         rd_data
);
  import frwl_pkg::*;

  queue_entry_t mem [QUEUE_DEPTH];
  queue_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/frwl_ctrl.sv =====
module frwl_ctrl #(
  parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  frwl_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output frwl_pkg::out_item_t            out_item,
  output logic                           wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  output frwl_pkg::queue_entry_t         wr_data,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  input  frwl_pkg::queue_entry_t         rd_data
);
  import frwl_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = AW + 1;

  state_t               state_r, state_nxt;
  lock_t                lock_r, lock_nxt;
  logic [READER_W-1:0]  rc_r, rc_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [GRANT_W-1:0]   grants_r, grants_nxt;
  out_item_t            pend_r, pend_nxt;
  out_item_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 out_free;
  logic [SW-1:0]        tail_sum;
  logic [AW-1:0]        tail;
  logic                 full;
  logic                 bad_agent;
  logic [READER_W-1:0]  rc_dec;
  logic                 can_grant;
  logic [AW-1:0]        head_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lock_r      <= LK_FREE;
      rc_r        <= '0;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lock_r      <= lock_nxt;
      rc_r        <= rc_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grants_r <= grants_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  // Shared compare/adjust unit: tail position, fullness, agent check, reader decrement, head step, grant check.
  assign tail_sum  = {1'b0, head_r} + SW'(count_r);
  assign tail      = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                    : AW'(tail_sum);
  assign full      = (count_r >= CW'(QUEUE_DEPTH));
  assign bad_agent = (9'(in_item.requester) >= 9'(AGENT_COUNT));
  assign rc_dec    = (rc_r != '0) ? rc_r - 1'b1 : rc_r;
  assign head_inc  = (SW'(head_r) + 1'b1 >= SW'(QUEUE_DEPTH)) ? '0 : head_r + 1'b1;
  assign can_grant = (count_r != '0) && (grants_r < GRANT_W'(MAX_GRANTS)) &&
                     (rd_data.mode == MODE_EXCL ? (lock_r == LK_FREE)
                                                : (lock_r != LK_EXCL && rc_r < READER_MAX));

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign rd_addr   = head_r;
  assign wr_addr   = tail;
  assign wr_data   = '{agent: in_item.requester, mode: in_item.lock_mode};

  always_comb begin
    state_nxt     = state_r;
    lock_nxt      = lock_r;
    rc_nxt        = rc_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    grants_nxt    = grants_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          grants_nxt = '0;
          state_nxt  = S_READ;
          if (in_item.operation == OP_LOCK) begin
            pend_nxt = '{status: ST_REJECTED, agent: in_item.requester,
                         granted_mode: in_item.lock_mode, last: 1'b0};
            if (!full && !bad_agent) begin
              wr_en           = 1'b1;
              count_nxt       = count_r + 1'b1;
              pend_nxt.status = ST_QUEUED;
            end
          end else begin
            pend_nxt = '{status: ST_FREE_RELEASE, agent: in_item.requester,
                         granted_mode: MODE_SHARED, last: 1'b0};
            if (lock_r != LK_FREE) begin
              pend_nxt.status = ST_RELEASED;
              if (lock_r == LK_SHARED) begin
                rc_nxt = rc_dec;
                if (rc_dec == '0) begin
                  lock_nxt = LK_FREE;
                end
              end else begin
                lock_nxt = LK_FREE;
                rc_nxt   = '0;
              end
            end
          end
        end
      end
      // head entry is read this cycle, valid in S_EVAL
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          if (can_grant) begin
            out_nxt.last = 1'b0;
            pend_nxt     = '{status: ST_GRANTED, agent: rd_data.agent,
                             granted_mode: rd_data.mode, last: 1'b0};
            head_nxt     = head_inc;
            count_nxt    = count_r - 1'b1;
            grants_nxt   = grants_r + 1'b1;
            if (rd_data.mode == MODE_EXCL) begin
              lock_nxt  = LK_EXCL;
              state_nxt = S_FLUSH;
            end else begin
              lock_nxt  = LK_SHARED;
              rc_nxt    = rc_r + 1'b1;
              state_nxt = S_READ;
            end
          end else begin
            out_nxt.last = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fair_reader_writer_lock_arbiter_core.sv =====
// Reader-writer lock arbiter with a first-come pending queue.
// Input channel (in_valid / in_stall / in_item): one beat is a lock request
// (shared or exclusive) or a release. in_stall is high while an item is being
// worked on; a new beat is taken only when the block is idle.
// Output channel (out_valid / out_stall / out_item): every input beat yields an
// acknowledge beat followed by one beat per grant; last marks the final beat.
// Sequence: the acknowledge is loaded into the output register after the accepted
// input beat passes through S_READ and S_EVAL, a shared grant after a further
// S_READ and S_EVAL, an exclusive grant from S_FLUSH, and the block takes the
// next input in the cycle after the last beat is loaded. The pacing is set by
// the single queue memory read port: each grant reads the head entry, then
// checks it against the lock state in the next cycle.
// A stalled output beat holds in the output register and the sequencer waits
// for it; nothing is dropped.
// Reset (synchronous, active low) frees the lock, empties the queue and
// drops any output beat; queue contents are not cleared.
module fair_reader_writer_lock_arbiter_core #(
  parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  frwl_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output frwl_pkg::out_item_t out_item
);
  import frwl_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  queue_entry_t  wr_data;
  queue_entry_t  rd_data;

  frwl_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  frwl_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== rtl/frwl_checker.sv =====
`include "fair_reader_writer_lock_arbiter_core_assert.svh"

module frwl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input frwl_pkg::out_item_t out_item
);
  import frwl_pkg::*;

  // a stalled output beat holds
  `FRWL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_item))

  // one item at a time: the cycle after a take, input is stalled
  `FRWL_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall)

  // release acknowledges carry no mode
  `FRWL_ASSERT_NOW(a_release_mode, clk, rst_n,
    out_valid && (out_item.status == ST_RELEASED || out_item.status == ST_FREE_RELEASE),
    out_item.granted_mode == MODE_SHARED)

  // an exclusive grant ends the scan
  `FRWL_ASSERT_NOW(a_excl_last, clk, rst_n,
    out_valid && out_item.status == ST_GRANTED && out_item.granted_mode == MODE_EXCL,
    out_item.last)

endmodule

bind fair_reader_writer_lock_arbiter_core frwl_checker u_frwl_checker (.*);

// ===== tb/tb_fair_reader_writer_lock_arbiter_core.sv =====
`timescale 1ns / 100ps

module tb_fair_reader_writer_lock_arbiter_core;
  import frwl_pkg::*;

  localparam int LINE_DEPTH  = QUEUE_DEPTH_DEF;
  localparam int ITEM_TARGET = 330;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct {
    logic       op;
    logic [3:0] req;
    logic       mode;
    bit         typed;
    status_t    st;
    logic [3:0] ag;
    logic       md;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // lock model state
  queue_entry_t wait_line [LINE_DEPTH];
  int           line_head = 0;
  int           line_cnt = 0;
  lock_t        lock_st = LK_FREE;
  int           reader_cnt = 0;

  out_item_t ack_grant_q [$];
  out_item_t want;
  plan_row_t plan [$];
  int        err_cnt = 0;
  int        n_sent = 0;
  int        cycle_cnt = 0;
  int        stall_left = 0;
  int        pick;
  bit        first_scen;

  fair_reader_writer_lock_arbiter_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  function automatic bit calm_stretch();
    return ((cycle_cnt / 300) % 4) == 2;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_stretch() || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_beat(status_t st, logic [3:0] ag, logic md);
    out_item_t b;
    b = '{status: st, agent: ag, granted_mode: md, last: 1'b0};
    ack_grant_q.insert(ack_grant_q.size(), b);
  endfunction

  // Apply one lock event to the model; return the number of beats it queues.
  function automatic int arbitrate_event(in_item_t it);
    int           n;
    int           grants;
    int           slot;
    bit           stop;
    queue_entry_t e;
    n = 0;
    grants = 0;
    stop = 1'b0;
    if (it.operation == OP_LOCK) begin
      if (line_cnt >= LINE_DEPTH || int'(it.requester) >= AGENT_COUNT) begin
        push_beat(ST_REJECTED, it.requester, it.lock_mode);
      end else begin
        slot = (line_head + line_cnt) % LINE_DEPTH;
        wait_line[slot] = '{agent: it.requester, mode: it.lock_mode};
        line_cnt++;
        push_beat(ST_QUEUED, it.requester, it.lock_mode);
      end
    end else if (lock_st == LK_FREE) begin
      push_beat(ST_FREE_RELEASE, it.requester, 1'b0);
    end else begin
      if (lock_st == LK_SHARED) begin
        if (reader_cnt > 0) reader_cnt--;
        if (reader_cnt == 0) lock_st = LK_FREE;
      end else begin
        lock_st = LK_FREE;
        reader_cnt = 0;
      end
      push_beat(ST_RELEASED, it.requester, 1'b0);
    end
    n = 1;
    while (!stop && line_cnt > 0 && grants < MAX_GRANTS) begin
      e = wait_line[line_head];
      if (e.mode == MODE_EXCL) begin
        if (lock_st != LK_FREE) stop = 1'b1;
        else lock_st = LK_EXCL;
      end else if (lock_st == LK_EXCL || reader_cnt >= int'(READER_MAX)) begin
        stop = 1'b1;
      end else begin
        reader_cnt++;
        lock_st = LK_SHARED;
      end
      if (!stop) begin
        line_head = (line_head + 1) % LINE_DEPTH;
        line_cnt--;
        push_beat(ST_GRANTED, e.agent, e.mode);
        n++;
        grants++;
        if (e.mode == MODE_EXCL) stop = 1'b1;
      end
    end
    ack_grant_q[ack_grant_q.size() - 1].last = 1'b1;
    return n;
  endfunction

  function automatic plan_row_t row(logic op, logic [3:0] req, logic mode, bit typed,
                                    status_t st, logic [3:0] ag, logic md);
    return '{op: op, req: req, mode: mode, typed: typed, st: st, ag: ag, md: md};
  endfunction

  task automatic send_beat(logic op, logic [3:0] req, logic mode, bit typed,
                           status_t st, logic [3:0] ag, logic md);
    int gap;
    int n;
    int idx;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{operation: op, requester: req, lock_mode: mode};
    do @(posedge clk); while (in_stall);
    n = arbitrate_event('{operation: op, requester: req, lock_mode: mode});
    n_sent++;
    // typed rows fix the acknowledge beat by hand
    if (typed) begin
      idx = ack_grant_q.size() - n;
      ack_grant_q[idx].status = st;
      ack_grant_q[idx].agent = ag;
      ack_grant_q[idx].granted_mode = md;
    end
  endtask

  task automatic send_plain(logic op, logic [3:0] req, logic mode);
    send_beat(op, req, mode, 1'b0, ST_GRANTED, 4'd0, 1'b0);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (ack_grant_q.size() != 0);
  endtask

  task automatic drain_lock();
    while (lock_st != LK_FREE)
      send_plain(OP_RELEASE, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (ack_grant_q.size() == 0) begin
        $error("unexpected beat: status %0d agent %0d", out_item.status, out_item.agent);
        err_cnt++;
      end else begin
        want = ack_grant_q.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          err_cnt++;
        end
        if (out_item.agent !== want.agent) begin
          $error("agent: expected %0d, got %0d", want.agent, out_item.agent);
          err_cnt++;
        end
        if (out_item.granted_mode !== want.granted_mode) begin
          $error("granted_mode: expected %0d, got %0d", want.granted_mode,
                 out_item.granted_mode);
          err_cnt++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    plan = '{
      row(OP_RELEASE, 4'd3,  MODE_SHARED, 1, ST_FREE_RELEASE, 4'd3,  1'b0),
      row(OP_LOCK,    4'd0,  MODE_SHARED, 1, ST_QUEUED,       4'd0,  1'b0),
      row(OP_LOCK,    4'd15, MODE_EXCL,   1, ST_QUEUED,       4'd15, 1'b1),
      // shared request behind a waiting writer must wait its turn
      row(OP_LOCK,    4'd5,  MODE_SHARED, 0, ST_GRANTED,      4'd0,  1'b0),
      row(OP_RELEASE, 4'd0,  MODE_EXCL,   1, ST_RELEASED,     4'd0,  1'b0),
      row(OP_RELEASE, 4'd15, MODE_SHARED, 0, ST_GRANTED,      4'd0,  1'b0),
      row(OP_RELEASE, 4'd5,  MODE_EXCL,   0, ST_GRANTED,      4'd0,  1'b0),
      row(OP_LOCK,    4'd7,  MODE_EXCL,   0, ST_GRANTED,      4'd0,  1'b0),
      // fill the line behind the writer
      row(OP_LOCK,    4'd0,  MODE_SHARED, 1, ST_QUEUED,       4'd0,  1'b0),
      row(OP_LOCK,    4'd1,  MODE_SHARED, 1, ST_QUEUED,       4'd1,  1'b0),
      row(OP_LOCK,    4'd2,  MODE_SHARED, 1, ST_QUEUED,       4'd2,  1'b0),
      row(OP_LOCK,    4'd3,  MODE_SHARED, 1, ST_QUEUED,       4'd3,  1'b0),
      row(OP_LOCK,    4'd4,  MODE_SHARED, 1, ST_QUEUED,       4'd4,  1'b0),
      row(OP_LOCK,    4'd5,  MODE_SHARED, 1, ST_QUEUED,       4'd5,  1'b0),
      row(OP_LOCK,    4'd6,  MODE_SHARED, 1, ST_QUEUED,       4'd6,  1'b0),
      row(OP_LOCK,    4'd7,  MODE_SHARED, 1, ST_QUEUED,       4'd7,  1'b0),
      row(OP_LOCK,    4'd8,  MODE_SHARED, 1, ST_QUEUED,       4'd8,  1'b0),
      row(OP_LOCK,    4'd9,  MODE_SHARED, 1, ST_QUEUED,       4'd9,  1'b0),
      row(OP_LOCK,    4'd10, MODE_SHARED, 1, ST_QUEUED,       4'd10, 1'b0),
      row(OP_LOCK,    4'd11, MODE_SHARED, 1, ST_QUEUED,       4'd11, 1'b0),
      row(OP_LOCK,    4'd12, MODE_SHARED, 1, ST_QUEUED,       4'd12, 1'b0),
      row(OP_LOCK,    4'd13, MODE_SHARED, 1, ST_QUEUED,       4'd13, 1'b0),
      row(OP_LOCK,    4'd14, MODE_SHARED, 1, ST_QUEUED,       4'd14, 1'b0),
      row(OP_LOCK,    4'd15, MODE_SHARED, 1, ST_QUEUED,       4'd15, 1'b0),
      row(OP_LOCK,    4'd9,  MODE_EXCL,   1, ST_REJECTED,     4'd9,  1'b1),
      // writer leaves: sixteen readers granted in one event
      row(OP_RELEASE, 4'd7,  MODE_SHARED, 1, ST_RELEASED,     4'd7,  1'b0),
      row(OP_RELEASE, 4'd2,  MODE_SHARED, 0, ST_GRANTED,      4'd0,  1'b0)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i])
      send_beat(plan[i].op, plan[i].req, plan[i].mode, plan[i].typed,
                plan[i].st, plan[i].ag, plan[i].md);
    wait_quiet();

    first_scen = 1'b1;
    while (n_sent < ITEM_TARGET) begin
      pick = first_scen ? 0 : $urandom_range(0, 99);
      first_scen = 1'b0;
      if (pick < 8) begin
        // flood with readers until the reader count saturates
        drain_lock();
        repeat (33) send_plain(OP_LOCK, 4'($urandom_range(0, 15)), MODE_SHARED);
        repeat (2) send_plain(OP_RELEASE, 4'($urandom_range(0, 15)), MODE_SHARED);
      end else if (pick < 16) begin
        // hold a writer and overrun the line
        drain_lock();
        send_plain(OP_LOCK, 4'($urandom_range(0, 15)), MODE_EXCL);
        repeat (17)
          send_plain(OP_LOCK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        drain_lock();
      end else if (pick < 20) begin
        wait_quiet();
      end else if (pick < 30) begin
        send_plain(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)));
      end else if (lock_st != LK_FREE && $urandom_range(0, 99) < 45) begin
        send_plain(OP_RELEASE, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end else begin
        send_plain(OP_LOCK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
    end

    wait_quiet();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/frwl_pkg.sv
rtl/frwl_queue.sv
rtl/frwl_ctrl.sv
rtl/fair_reader_writer_lock_arbiter_core.sv
rtl/frwl_checker.sv
tb/tb_fair_reader_writer_lock_arbiter_core.sv
